// ----- src/peak_to_peak_artifact_rejector_core_assert.svh -----
// assertion macros shared by the rejector modules
`ifndef PEAK_TO_PEAK_ARTIFACT_REJECTOR_CORE_ASSERT_SVH
`define PEAK_TO_PEAK_ARTIFACT_REJECTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, masked while reset is asserted
`define PPAR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also live during reset
`define PPAR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPAR_ASSERT(lbl, prop, msg)
`define PPAR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/ppar_pkg.sv -----
// shared types and constants of the peak-to-peak rejector
package ppar_pkg;

    localparam int CHAN_W     = 9;
    localparam int CLASS_W    = 3;
    localparam int VALUE_W    = 32;
    localparam int THR_W      = 32;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    // epoch tags kept with every channel entry
    localparam int TAG_W = 8;
    localparam logic [TAG_W-1:0] TAG_CLEAR = '0;
    localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_LAST  = '1;

    // verdict queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    // channel classes
    localparam logic [CLASS_W-1:0] CLASS_MAG  = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_GRAD = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_EEG  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_EOG  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MAG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_GRAD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_EEG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_EOG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MASK = 3'd4;

    // bits of the scan enable mask
    localparam int MASK_MAG  = 0;
    localparam int MASK_GRAD = 1;
    localparam int MASK_EEG  = 2;
    localparam int MASK_EOG  = 3;

    typedef struct packed {
        logic [THR_W-1:0]  thr_mag;
        logic [THR_W-1:0]  thr_grad;
        logic [THR_W-1:0]  thr_eeg;
        logic [THR_W-1:0]  thr_eog;
        logic [MASK_W-1:0] scan_mask;
    } ppar_cfg_t;

    // one sample after its min/max update, on its way to the verdict logic
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               scan;
        logic [CHAN_W-1:0]  chan;
        logic [THR_W-1:0]   limit;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
    } ppar_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic              reject;
    } ppar_verdict_t;

endpackage

// ----- src/ppar_track.sv -----
// per-channel min/max tracking over the channel memory, with epoch tags
`include "peak_to_peak_artifact_rejector_core_assert.svh"
module ppar_track #(
    parameter int MAX_CHANNELS = 512,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppar_pkg::ppar_cfg_t               cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ppar_pkg::CHAN_W-1:0]       channel_index,
    input  logic [ppar_pkg::CLASS_W-1:0]      channel_class,
    input  logic [ppar_pkg::VALUE_W-1:0]      sample_value,
    input  logic                              epoch_end,
    input  logic [ppar_pkg::OUTQ_CNT_W-1:0]   outq_count,
    output ppar_pkg::ppar_item_t              item
);
    import ppar_pkg::*;

    localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WORD_W = TAG_W + 2 * SAMPLE_BITS;
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_CHANNELS - 1);

    // memory word: {tag, max, min}
    logic [WORD_W-1:0] chan_mem [MAX_CHANNELS];
    logic [WORD_W-1:0] rd_word_reg;

    logic                    accept;
    logic                    in_range;
    logic                    meg_on;
    logic                    cls_scan;
    logic [THR_W-1:0]        cls_limit;
    logic [ADDR_W-1:0]       s0_addr;

    logic                    s1_valid_reg;
    logic                    s1_last_reg;
    logic                    s1_scan_reg;
    logic [ADDR_W-1:0]       s1_addr_reg;
    logic [CHAN_W-1:0]       s1_chan_reg;
    logic [THR_W-1:0]        s1_limit_reg;
    logic signed [SAMPLE_BITS-1:0] s1_value_reg;

    logic                    fwd_valid_reg;
    logic [ADDR_W-1:0]       fwd_addr_reg;
    logic [WORD_W-1:0]       fwd_word_reg;

    logic [TAG_W-1:0]        epoch_reg;
    logic                    clr_active_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;

    logic [WORD_W-1:0]       s1_word;
    logic [TAG_W-1:0]        old_tag;
    logic signed [SAMPLE_BITS-1:0] old_lo;
    logic signed [SAMPLE_BITS-1:0] old_hi;
    logic signed [SAMPLE_BITS-1:0] new_lo;
    logic signed [SAMPLE_BITS-1:0] new_hi;
    logic                    seen;
    logic                    s1_write;
    logic                    wrap_hold;
    logic [OUTQ_CNT_W-1:0]   pending;

    logic                    mem_wr_en;
    logic [ADDR_W-1:0]       mem_wr_addr;
    logic [WORD_W-1:0]       mem_wr_word;

    ppar_item_t              item_reg;

    // sample stage: class decode and memory read
    always_comb
    begin
        meg_on    = cfg.scan_mask[MASK_MAG] | cfg.scan_mask[MASK_GRAD];
        cls_scan  = 1'b0;
        cls_limit = '0;
        unique case (channel_class)
            CLASS_MAG:
            begin
                cls_scan  = meg_on;
                cls_limit = cfg.thr_mag;
            end
            CLASS_GRAD:
            begin
                cls_scan  = meg_on;
                cls_limit = cfg.thr_grad;
            end
            CLASS_EEG:
            begin
                cls_scan  = cfg.scan_mask[MASK_EEG];
                cls_limit = cfg.thr_eeg;
            end
            CLASS_EOG:
            begin
                cls_scan  = cfg.scan_mask[MASK_EOG];
                cls_limit = cfg.thr_eog;
            end
            default:
            begin
                cls_scan  = 1'b0;
                cls_limit = '0;
            end
        endcase
    end

    assign in_range = ({{(32 - CHAN_W){1'b0}}, channel_index} < 32'(MAX_CHANNELS));
    assign s0_addr  = ADDR_W'(channel_index);

    // verdicts that may still land in the queue
    assign pending = outq_count
                   + OUTQ_CNT_W'(s1_valid_reg & s1_last_reg)
                   + OUTQ_CNT_W'(item_reg.valid & item_reg.last);

    // a last sample on the final tag holds input until the tag sweep is done
    assign wrap_hold = s1_valid_reg && s1_last_reg && (epoch_reg == TAG_LAST);
    assign in_ready  = !clr_active_reg && !wrap_hold
                     && (pending < OUTQ_CNT_W'(OUTQ_DEPTH));
    assign accept    = in_valid && in_ready;

    // update stage: forward the previous write to the same channel
    assign s1_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
                   ? fwd_word_reg : rd_word_reg;
    assign old_tag = s1_word[WORD_W-1 -: TAG_W];
    assign old_hi  = s1_word[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign old_lo  = s1_word[SAMPLE_BITS-1:0];
    assign seen    = (old_tag == epoch_reg);
    assign new_lo  = (!seen || (s1_value_reg < old_lo)) ? s1_value_reg : old_lo;
    assign new_hi  = (!seen || (s1_value_reg > old_hi)) ? s1_value_reg : old_hi;
    assign s1_write = s1_valid_reg && s1_scan_reg;

    assign mem_wr_en   = s1_write || clr_active_reg;
    assign mem_wr_addr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wr_word = clr_active_reg ? {TAG_CLEAR, {(2 * SAMPLE_BITS){1'b0}}}
                                        : {epoch_reg, new_hi, new_lo};

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            chan_mem[mem_wr_addr] <= mem_wr_word;
        end
        rd_word_reg <= chan_mem[s0_addr];
    end

    // payload of the pipeline
    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= s0_addr;
        s1_chan_reg  <= channel_index;
        s1_limit_reg <= cls_limit;
        s1_value_reg <= sample_value[SAMPLE_BITS-1:0];
        fwd_addr_reg <= s1_addr_reg;
        fwd_word_reg <= {epoch_reg, new_hi, new_lo};
    end

    // control: stage valids, item register, epoch tag and tag sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_scan_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            item_reg.valid <= 1'b0;
            item_reg.last  <= 1'b0;
            item_reg.scan  <= 1'b0;
            item_reg.chan  <= '0;
            item_reg.limit <= '0;
            item_reg.lo    <= '0;
            item_reg.hi    <= '0;
            epoch_reg      <= TAG_FIRST;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= accept;
            s1_last_reg    <= accept && epoch_end;
            s1_scan_reg    <= accept && in_range && cls_scan;
            fwd_valid_reg  <= s1_write;
            item_reg.valid <= s1_valid_reg;
            item_reg.last  <= s1_valid_reg && s1_last_reg;
            item_reg.scan  <= s1_write;
            item_reg.chan  <= s1_chan_reg;
            item_reg.limit <= s1_limit_reg;
            item_reg.lo    <= VALUE_W'(new_lo);
            item_reg.hi    <= VALUE_W'(new_hi);

            if (s1_valid_reg && s1_last_reg)
            begin
                epoch_reg <= (epoch_reg == TAG_LAST) ? TAG_FIRST : epoch_reg + TAG_FIRST;
            end

            if (clr_active_reg)
            begin
                if (clr_addr_reg == ADDR_LAST)
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            else if (wrap_hold)
            begin
                clr_active_reg <= 1'b1;
                clr_addr_reg   <= '0;
            end
        end
    end

    assign item = item_reg;

    `PPAR_ASSERT_ALWAYS(a_no_update_in_sweep, s1_write |-> !clr_active_reg,
        "update during tag sweep")
    `PPAR_ASSERT(a_wrap_starts_sweep,
        wrap_hold |=> (clr_active_reg && (epoch_reg == TAG_FIRST)),
        "tag wrap without sweep")
    `PPAR_ASSERT(a_last_moves_epoch,
        (s1_valid_reg && s1_last_reg) |=> (epoch_reg != $past(epoch_reg)),
        "epoch tag did not advance")

endmodule

// ----- src/ppar_verdict.sv -----
// peak-to-peak test, sticky reject state and verdict queue
`include "peak_to_peak_artifact_rejector_core_assert.svh"
module ppar_verdict (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ppar_pkg::ppar_item_t            item,
    output logic [ppar_pkg::OUTQ_CNT_W-1:0] outq_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ppar_pkg::ppar_verdict_t         out_data
);
    import ppar_pkg::*;

    logic [VALUE_W:0]      diff;
    logic                  exceed;
    logic                  sticky_now;
    logic [CHAN_W-1:0]     first_now;
    logic                  push;
    logic                  pop;
    ppar_verdict_t         push_data;

    logic                  sticky_reg;
    logic [CHAN_W-1:0]     first_reg;
    ppar_verdict_t         outq_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] outq_count_reg;

    // max is never below min, so the difference is non-negative
    assign diff   = {item.hi[VALUE_W-1], item.hi} - {item.lo[VALUE_W-1], item.lo};
    assign exceed = item.valid && item.scan && (diff > (VALUE_W + 1)'(item.limit));

    assign sticky_now = sticky_reg | exceed;
    assign first_now  = (exceed && (!sticky_reg || (item.chan < first_reg)))
                      ? item.chan : first_reg;

    assign push             = item.valid && item.last;
    assign pop              = out_valid && out_ready;
    assign push_data.reject = sticky_now;
    assign push_data.chan   = sticky_now ? first_now : '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            outq_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg     <= 1'b0;
            first_reg      <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            outq_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                sticky_reg <= 1'b0;
                first_reg  <= '0;
                wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(1);
            end
            else if (item.valid)
            begin
                sticky_reg <= sticky_now;
                first_reg  <= first_now;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(1);
            end
            if (push && !pop)
            begin
                outq_count_reg <= outq_count_reg + OUTQ_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                outq_count_reg <= outq_count_reg - OUTQ_CNT_W'(1);
            end
        end
    end

    assign out_valid  = (outq_count_reg != '0);
    assign out_data   = outq_mem[rd_ptr_reg];
    assign outq_count = outq_count_reg;

    `PPAR_ASSERT(a_outq_no_overflow, (push && !pop) |-> (outq_count_reg < OUTQ_CNT_W'(OUTQ_DEPTH)), "verdict queue overflow")
    `PPAR_ASSERT(a_clean_verdict_zero, (out_valid && !out_data.reject) |-> (out_data.chan == '0), "clean verdict carries a channel")
    `PPAR_ASSERT(a_epoch_state_cleared, push |=> (!sticky_reg && (first_reg == '0)), "reject state not cleared at epoch end")

endmodule

// ----- src/peak_to_peak_artifact_rejector_core.sv -----
// top level of the peak-to-peak epoch rejector
//
//  channel  dir  transaction                                  handshake
//  s_       in   one sample: channel, class, value, epoch end s_tvalid / s_tready
//  m_       out  one verdict per epoch: reject flag, channel  m_tvalid / m_tready
//  cfg_     in   one register write: index, data              cfg_valid / cfg_ready
//
//  one sample per cycle while s_tready is high; a verdict is queued once the epoch's last sample
//  is taken (min/max update on the memory read, then the peak-to-peak test into the queue)
//  after reset, s_tready stays low while the tags of all MAX_CHANNELS channel memory
//  entries are swept; the same sweep runs after every 255th epoch
//  a stalled m_ side fills a four-deep verdict queue; outside the sweeps, s_tready drops
//  only when verdicts already queued or in flight would not fit
//  cfg_ready is always high; writes above the register list are ignored
`include "peak_to_peak_artifact_rejector_core_assert.svh"
module peak_to_peak_artifact_rejector_core #(
    parameter int MAX_CHANNELS = 512,
    parameter int SAMPLE_BITS  = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ppar_pkg::S_TDATA_W-1:0]     s_tdata,   // channel_index[8:0], sample_value[40:9]
    input  logic [ppar_pkg::CLASS_W-1:0]       s_tuser,   // channel_class[2:0]
    input  logic                               s_tlast,   // epoch_end
    // verdict stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ppar_pkg::M_TDATA_W-1:0]     m_tdata,   // reject_epoch[0], reject_channel[9:1]
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppar_pkg::THR_W-1:0]         cfg_data
);
    import ppar_pkg::*;

    ppar_cfg_t             cfg_reg;
    ppar_item_t            item;
    ppar_verdict_t         verdict;
    logic [OUTQ_CNT_W-1:0] outq_count;
    logic                  cfg_write;

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_THR_MAG:   cfg_reg.thr_mag   <= cfg_data;
                CFG_THR_GRAD:  cfg_reg.thr_grad  <= cfg_data;
                CFG_THR_EEG:   cfg_reg.thr_eeg   <= cfg_data;
                CFG_THR_EOG:   cfg_reg.thr_eog   <= cfg_data;
                CFG_SCAN_MASK: cfg_reg.scan_mask <= cfg_data[MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // channel memory, min/max update and epoch tagging
    ppar_track #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_track (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .channel_index (s_tdata[CHAN_W-1:0]),
        .channel_class (s_tuser),
        .sample_value  (s_tdata[CHAN_W +: VALUE_W]),
        .epoch_end     (s_tlast),
        .outq_count    (outq_count),
        .item          (item)
    );

    // threshold test, sticky reject and verdict queue
    ppar_verdict u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .outq_count (outq_count),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (verdict)
    );

    assign m_tdata = {{(M_TDATA_W - CHAN_W - 1){1'b0}}, verdict.chan, verdict.reject};

    // a full queue must hold input off
    `PPAR_ASSERT(a_full_queue_stalls,
        (outq_count == OUTQ_CNT_W'(OUTQ_DEPTH)) |-> !s_tready,
        "input taken with full verdict queue")
    // a verdict waiting for m_tready stays put
    `PPAR_ASSERT(a_verdict_holds,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
        "stalled verdict changed")
    // no verdict without an epoch end having been taken
    `PPAR_ASSERT(a_verdict_needs_last,
        ($rose(m_tvalid)) |-> $past(item.valid && item.last),
        "verdict without epoch end")

endmodule

// ----- bench/tb_peak_to_peak_artifact_rejector_core.sv -----
// self-checking bench for the peak-to-peak epoch rejector, checked against a predictor
`timescale 1ns / 100ps
module tb_peak_to_peak_artifact_rejector_core;

    import ppar_pkg::*;

    localparam int CHANNELS       = 512;
    localparam int IDLE_PCT       = 32;     // chance in a hundred that a side idles
    localparam int QUIET_LIMIT    = 5000;   // cycles with no transaction before giving up
    localparam int SETTLE_CYCLES  = 8;      // margin over the verdict latency
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 220;
    localparam int STEADY_PHASE   = 3;      // both sides run without idling here

    // classes outside the four scanned ones
    localparam logic [CLASS_W-1:0] CLASS_EXCLUDED = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_TOP      = 3'd7;

    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [THR_W-1:0]   THR_FULL  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CHAN_W-1:0]  ch;
        logic [CLASS_W-1:0] cls;
        logic [VALUE_W-1:0] val;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic              reject;
        logic [CHAN_W-1:0] chan;
    } verdict_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // channel_index[8:0], sample_value[40:9]
    logic [CLASS_W-1:0]    s_tuser  = '0;   // channel_class[2:0]
    logic                  s_tlast  = 1'b0; // epoch_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // reject_epoch[0], reject_channel[9:1]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [THR_W-1:0]      cfg_data  = '0;

    peak_to_peak_artifact_rejector_core #(
        .MAX_CHANNELS (CHANNELS),
        .SAMPLE_BITS  (VALUE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // samples waiting to be driven, verdicts waiting to come out
    sample_t  sample_feed[$];
    verdict_t verdicts_due[$];

    // no-idle mode for both sides, set by the stimulus sequence
    logic steady = 1'b0;

    int mismatches      = 0;
    int samples_taken   = 0;
    int epochs_closed   = 0;
    int verdicts_seen   = 0;
    int rejects_seen    = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------
    // predictor: register copies and per-epoch channel tracking
    // ------------------------------------------------------------------
    logic [THR_W-1:0]          lim_mag  = '0;
    logic [THR_W-1:0]          lim_grad = '0;
    logic [THR_W-1:0]          lim_eeg  = '0;
    logic [THR_W-1:0]          lim_eog  = '0;
    logic [MASK_W-1:0]         scan_on  = '0;

    logic signed [VALUE_W-1:0] span_lo [CHANNELS];
    logic signed [VALUE_W-1:0] span_hi [CHANNELS];
    logic                      seen    [CHANNELS];
    logic                      epoch_rejected = 1'b0;
    logic [CHAN_W-1:0]         worst_chan     = '0;

    initial
    begin
        for (int i = 0; i < CHANNELS; i++)
            seen[i] = 1'b0;
    end

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [THR_W-1:0] val);
        case (idx)
            CFG_THR_MAG:   lim_mag  = val;
            CFG_THR_GRAD:  lim_grad = val;
            CFG_THR_EEG:   lim_eeg  = val;
            CFG_THR_EOG:   lim_eog  = val;
            CFG_SCAN_MASK: scan_on  = val[MASK_W-1:0];
            default: ;
        endcase
    endfunction

    // update min/max for one accepted sample; on epoch end queue the verdict
    function automatic void track_sample(input sample_t s);
        logic                      scan;
        logic [THR_W-1:0]          limit;
        logic signed [VALUE_W-1:0] v;
        longint                    span;
        verdict_t                  vd;
        scan  = 1'b0;
        limit = '0;
        v     = signed'(s.val);
        // both MEG classes follow either MEG enable bit
        case (s.cls)
            CLASS_MAG:
            begin
                limit = lim_mag;
                scan  = scan_on[MASK_MAG] | scan_on[MASK_GRAD];
            end
            CLASS_GRAD:
            begin
                limit = lim_grad;
                scan  = scan_on[MASK_MAG] | scan_on[MASK_GRAD];
            end
            CLASS_EEG:
            begin
                limit = lim_eeg;
                scan  = scan_on[MASK_EEG];
            end
            CLASS_EOG:
            begin
                limit = lim_eog;
                scan  = scan_on[MASK_EOG];
            end
            default:    scan = 1'b0;
        endcase
        if (scan && int'(s.ch) < CHANNELS)
        begin
            if (!seen[s.ch])
            begin
                seen[s.ch]    = 1'b1;
                span_lo[s.ch] = v;
                span_hi[s.ch] = v;
            end
            else
            begin
                if (v < span_lo[s.ch]) span_lo[s.ch] = v;
                if (v > span_hi[s.ch]) span_hi[s.ch] = v;
            end
            // exact difference, no wrap, strict unsigned compare
            span = longint'(span_hi[s.ch]) - longint'(span_lo[s.ch]);
            if (span > longint'({32'b0, limit}))
            begin
                if (!epoch_rejected || s.ch < worst_chan)
                    worst_chan = s.ch;
                epoch_rejected = 1'b1;
            end
        end
        if (s.last)
        begin
            vd.reject = epoch_rejected;
            vd.chan   = epoch_rejected ? worst_chan : '0;
            verdicts_due.push_back(vd);
            for (int i = 0; i < CHANNELS; i++)
                seen[i] = 1'b0;
            epoch_rejected = 1'b0;
            worst_chan     = '0;
            epochs_closed++;
        end
    endfunction

    // ------------------------------------------------------------------
    // sample driver: loads the next item when the bus is free
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_t nxt;
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (sample_feed.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt      = sample_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, nxt.val, nxt.ch};
                s_tuser  <= nxt.cls;
                s_tlast  <= nxt.last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // verdict side back-pressure
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // monitor: predict on sample transactions, check verdict transactions
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_t  got_in;
        verdict_t want;
        if (rst_n && s_tvalid && s_tready)
        begin
            got_in.ch   = s_tdata[CHAN_W-1:0];
            got_in.val  = s_tdata[CHAN_W +: VALUE_W];
            got_in.cls  = s_tuser;
            got_in.last = s_tlast;
            track_sample(got_in);
            samples_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            verdicts_seen++;
            if (m_tdata[0])
                rejects_seen++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual reject=%0b channel=%0d",
                         $time, m_tdata[0], m_tdata[9:1]);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[0] !== want.reject)
                begin
                    $display("%0t: reject_epoch mismatch, expected %0b actual %0b",
                             $time, want.reject, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[9:1] !== want.chan)
                begin
                    $display("%0t: reject_channel mismatch, expected %0d actual %0d",
                             $time, want.chan, m_tdata[9:1]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: counts cycles in which no transaction happens on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic [CLASS_W-1:0] cls,
                               input logic [VALUE_W-1:0] val, input logic last);
        sample_t s;
        s.ch   = ch;
        s.cls  = cls;
        s.val  = val;
        s.last = last;
        sample_feed.push_back(s);
    endtask

    // called just after a rising edge; returns right after the write transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    // sender holds off until every sample is taken and every verdict is back
    task automatic drain;
        do @(negedge clk);
        while (sample_feed.size() != 0 || s_tvalid || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [THR_W-1:0] pick_limit();
        case ($urandom_range(5))
            0:       return '0;
            1:       return THR_FULL;
            2:       return $urandom();
            default: return $urandom_range(4000);
        endcase
    endfunction

    task automatic program_all(input logic [MASK_W-1:0] mask, input logic extremes);
        @(posedge clk);
        write_reg(CFG_THR_MAG,  extremes ? '0 : pick_limit());
        write_reg(CFG_THR_GRAD, extremes ? THR_FULL : pick_limit());
        write_reg(CFG_THR_EEG,  pick_limit());
        write_reg(CFG_THR_EOG,  pick_limit());
        write_reg(CFG_SCAN_MASK, {{(THR_W-MASK_W){1'b0}}, mask});
        cfg_valid <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // one well-formed epoch over a few channels, salted with stray samples
    task automatic queue_epoch(output int len);
        logic [CHAN_W-1:0]  chans   [8];
        logic [CLASS_W-1:0] classes [8];
        int                 bases   [8];
        int                 nch, pick, spread;
        logic [CHAN_W-1:0]  ch;
        logic [CLASS_W-1:0] cls;
        logic [VALUE_W-1:0] v;
        nch    = $urandom_range(1, 8);
        len    = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
        spread = $urandom_range(3000);
        for (int i = 0; i < nch; i++)
        begin
            case ($urandom_range(9))
                0:       chans[i] = '0;
                1:       chans[i] = '1;
                default: chans[i] = CHAN_W'($urandom_range(CHANNELS - 1));
            endcase
            classes[i] = CLASS_W'(($urandom_range(9) < 8)
                                  ? $urandom_range(CLASS_MAG, CLASS_EOG)
                                  : $urandom_range(CLASS_TOP));
            bases[i]   = $urandom();
        end
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(nch - 1);
            ch   = chans[pick];
            cls  = classes[pick];
            // stray sample with arbitrary channel and class
            if ($urandom_range(9) == 0)
            begin
                ch  = CHAN_W'($urandom_range(CHANNELS - 1));
                cls = CLASS_W'($urandom_range(CLASS_TOP));
            end
            case ($urandom_range(19))
                0:       v = VALUE_MIN;
                1:       v = VALUE_MAX;
                2, 3:    v = $urandom();
                default: v = bases[pick] + $urandom_range(spread) - spread / 2;
            endcase
            push_sample(ch, cls, v, k == len - 1);
        end
    endtask

    initial
    begin
        logic [MASK_W-1:0] masks [RANDOM_PHASES];
        int                queued, len;
        masks = '{4'hF, 4'h0, 4'h2, 4'h5, 4'hA, 4'h1, 4'h0, 4'hF};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // only the magnetometer bit, thresholds still at reset (zero)
        @(posedge clk);
        write_reg(CFG_SCAN_MASK, 32'h1 << MASK_MAG);
        cfg_valid <= 1'b0;
        @(negedge clk);
        settings_used++;

        // gradiometer follows the magnetometer enable and rejects at zero limit
        push_sample(9'd5, CLASS_GRAD, 32'd10, 1'b0);
        push_sample(9'd5, CLASS_GRAD, 32'd11, 1'b0);
        push_sample(9'd3, CLASS_MAG,  32'd0,  1'b0);
        push_sample(9'd3, CLASS_MAG,  32'd0,  1'b0);
        // excluded and unknown classes never scanned, however wide the swing
        push_sample(9'd1, CLASS_EXCLUDED, VALUE_MIN, 1'b0);
        push_sample(9'd1, CLASS_EXCLUDED, VALUE_MAX, 1'b0);
        for (int c = CLASS_EOG + 1; c <= CLASS_TOP; c++)
        begin
            push_sample(9'd0, c[CLASS_W-1:0], VALUE_MIN, 1'b0);
            push_sample(9'd0, c[CLASS_W-1:0], VALUE_MAX, 1'b0);
        end
        // disabled EEG class is ignored
        push_sample(9'd2, CLASS_EEG, VALUE_MIN, 1'b0);
        push_sample(9'd2, CLASS_EEG, VALUE_MAX, 1'b0);
        push_sample(9'd511, CLASS_EOG, 32'h5A5A_5A5A, 1'b1);
        // lone epoch end on an excluded channel, no reject
        push_sample(9'd0, CLASS_EXCLUDED, 32'hFFFF_FFFF, 1'b1);
        drain();

        // limit extremes, magnetometer on through the gradiometer bit
        @(posedge clk);
        write_reg(CFG_THR_MAG,  THR_FULL);
        write_reg(CFG_THR_GRAD, THR_FULL - 1);
        write_reg(CFG_THR_EEG,  32'd100);
        write_reg(CFG_THR_EOG,  '0);
        write_reg(CFG_SCAN_MASK, (32'h1 << MASK_GRAD) | (32'h1 << MASK_EEG) | (32'h1 << MASK_EOG));
        cfg_valid <= 1'b0;
        @(negedge clk);
        settings_used++;

        // full-scale swing equals the magnetometer limit: no reject
        push_sample(9'd10, CLASS_MAG, VALUE_MIN, 1'b0);
        push_sample(9'd10, CLASS_MAG, VALUE_MAX, 1'b0);
        // same swing is one above the gradiometer limit
        push_sample(9'd20, CLASS_GRAD, VALUE_MAX, 1'b0);
        push_sample(9'd20, CLASS_GRAD, VALUE_MIN, 1'b0);
        // swing of exactly the limit passes, one more rejects a lower channel
        push_sample(9'd7, CLASS_EEG, 32'd0,   1'b0);
        push_sample(9'd7, CLASS_EEG, 32'd100, 1'b0);
        push_sample(9'd7, CLASS_EEG, -32'sd1, 1'b0);
        // flat EOG channel at zero limit stays clean
        push_sample(9'd300, CLASS_EOG, 32'h1234_5678, 1'b0);
        push_sample(9'd300, CLASS_EOG, 32'h1234_5678, 1'b1);
        // first scanned sample of a channel cannot reject
        push_sample(9'd511, CLASS_EEG, VALUE_MIN, 1'b1);
        drain();

        // random phases, each with a fresh register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_all(masks[p], p == 0);
            steady = (p == STEADY_PHASE);
            queued = 0;
            while (queued < PHASE_SAMPLES)
            begin
                queue_epoch(len);
                queued += len;
            end
            drain();
            steady = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d samples in %0d epochs over %0d register settings",
                 samples_taken, epochs_closed, settings_used);
        $display("checked %0d verdicts, %0d of them rejections", verdicts_seen, rejects_seen);
        if (verdicts_due.size() != 0)
            $display("%0t: %0d verdicts expected but never seen", $time, verdicts_due.size());
        if (mismatches == 0 && verdicts_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
